// ----- rtl/aabb_frustum_cull_macros.svh -----
// Assertion macros shared by the culling block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("culling block: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("culling block: next-cycle check failed");

`else

`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AFC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/afc_pkg.sv -----
`timescale 1ns / 1ps

package afc_pkg;

    // Frustum size and coordinate width.
    localparam int PLANE_COUNT = 6;
    localparam int COORD_BITS  = 16;

    // Register file: six 64-bit plane registers at 8-byte spacing.
    localparam int CFG_REGS = 6;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = $clog2(CFG_REGS);
    localparam int PADDR_W  = IDX_W + 3;

    // Plane fields: Q1.14 normal components and a Q15.0 offset.
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int OFF_W     = 16;

    // One product per axis; the sum of three products and the aligned offset is exact.
    localparam int AXES     = 3;
    localparam int CORNERS  = 2;
    localparam int CORNER_P = 0;
    localparam int CORNER_N = 1;
    localparam int PROD_W   = NORM_W + COORD_BITS;
    localparam int OFF_SH_W = OFF_W + NORM_FRAC;
    localparam int DIST_W   = ((PROD_W > OFF_SH_W) ? PROD_W : OFF_SH_W) + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [NORM_W-1:0]     t_norm;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [DIST_W-1:0]     t_dist;

    // Packed plane register layout, offset in the top quarter.
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [NORM_W-1:0] nz;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nx;
    } t_plane;

    typedef enum logic [1:0] {
        VERDICT_INSIDE  = 2'd0,
        VERDICT_OVERLAP = 2'd1,
        VERDICT_OUTSIDE = 2'd2
    } t_verdict;

    // Normal component of a plane for one axis.
    function automatic t_norm plane_normal(input t_plane pl, input int axis);
        t_norm n;
        case (axis)
            0: begin
                n = t_norm'(pl.nx);
            end
            1: begin
                n = t_norm'(pl.ny);
            end
            default: begin
                n = t_norm'(pl.nz);
            end
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/afc_regs.sv -----
`timescale 1ns / 1ps

module afc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]   paddr,
    input  logic [afc_pkg::DATA_W-1:0]    pwdata,
    output logic [afc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output afc_pkg::t_plane               o_planes [afc_pkg::PLANE_COUNT]
);
    import afc_pkg::*;

    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    // Write strobe at the access phase; registers sit on 8-byte boundaries.
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign pready  = 1'b1;

    // One register per writable plane; planes past the list stay zero and never cull.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        if (p < CFG_REGS) begin : g_reg
            t_plane r_plane;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_plane <= '0;
                end else if (wr_en && (reg_idx == IDX_W'(p))) begin
                    r_plane <= t_plane'(pwdata);
                end
            end

            assign o_planes[p] = r_plane;
        end else begin : g_none
            assign o_planes[p] = '0;
        end
    end

    // Read-back; addresses outside the list read as zero.
    always_comb begin
        prdata = '0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if ((p < CFG_REGS) && (reg_idx == IDX_W'(p))) begin
                prdata = o_planes[p];
            end
        end
    end

endmodule

// ----- rtl/afc_dot.sv -----
`timescale 1ns / 1ps

module afc_dot (
    input  logic            i_clk,
    input  logic            i_load,
    input  afc_pkg::t_coord i_min [afc_pkg::AXES],
    input  afc_pkg::t_coord i_max [afc_pkg::AXES],
    input  afc_pkg::t_plane i_planes [afc_pkg::PLANE_COUNT],
    output afc_pkg::t_prod  o_prod [afc_pkg::PLANE_COUNT][afc_pkg::CORNERS][afc_pkg::AXES],
    output logic            o_empty
);
    import afc_pkg::*;

    t_prod n_prod [PLANE_COUNT][CORNERS][AXES];
    t_prod r_prod [PLANE_COUNT][CORNERS][AXES];
    logic  n_empty;
    logic  r_empty;

    // Corner choice per plane and axis, then one product per corner and axis.
    // A non-negative normal component takes the maximum for the positive corner.
    always_comb begin
        t_norm nrm;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int k = 0; k < AXES; k++) begin
                nrm = plane_normal(i_planes[p], k);
                if (nrm[NORM_W-1]) begin
                    n_prod[p][CORNER_P][k] = t_prod'(nrm) * t_prod'(i_min[k]);
                    n_prod[p][CORNER_N][k] = t_prod'(nrm) * t_prod'(i_max[k]);
                end else begin
                    n_prod[p][CORNER_P][k] = t_prod'(nrm) * t_prod'(i_max[k]);
                    n_prod[p][CORNER_N][k] = t_prod'(nrm) * t_prod'(i_min[k]);
                end
            end
        end
    end

    // A box with no volume on any axis is outside regardless of the planes.
    always_comb begin
        n_empty = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            if (!(i_max[k] > i_min[k])) begin
                n_empty = 1'b1;
            end
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod  <= n_prod;
            r_empty <= n_empty;
        end
    end

    assign o_prod  = r_prod;
    assign o_empty = r_empty;

endmodule

// ----- rtl/afc_class.sv -----
`timescale 1ns / 1ps

module afc_class (
    input  logic              i_clk,
    input  logic              i_load,
    input  afc_pkg::t_prod    i_prod [afc_pkg::PLANE_COUNT][afc_pkg::CORNERS][afc_pkg::AXES],
    input  logic              i_empty,
    input  afc_pkg::t_plane   i_planes [afc_pkg::PLANE_COUNT],
    output afc_pkg::t_verdict o_verdict
);
    import afc_pkg::*;

    logic     any_out;
    logic     any_over;
    t_verdict n_verdict;
    t_verdict r_verdict;

    // Signed distance of both corners to every plane, offset aligned to the product scale.
    always_comb begin
        t_dist off_al;
        t_dist corner_dist;
        any_out  = 1'b0;
        any_over = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            off_al = t_dist'($signed(i_planes[p].off)) <<< NORM_FRAC;
            for (int c = 0; c < CORNERS; c++) begin
                corner_dist = t_dist'(i_prod[p][c][0]) + t_dist'(i_prod[p][c][1])
                            + t_dist'(i_prod[p][c][2]) + off_al;
                if (corner_dist > t_dist'(0)) begin
                    if (c == CORNER_N) begin
                        any_out = 1'b1;
                    end else begin
                        any_over = 1'b1;
                    end
                end
            end
        end
    end

    // Outside wins over overlap; inside when no corner is in front of any plane.
    always_comb begin
        if (i_empty || any_out) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (any_over) begin
            n_verdict = VERDICT_OVERLAP;
        end else begin
            n_verdict = VERDICT_INSIDE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_verdict = r_verdict;

endmodule

// ----- rtl/aabb_frustum_cull.sv -----
// Axis-aligned box against frustum planes, three register stages: input, products, verdict.
// The box passes the input, product and verdict registers in turn before the verdict is valid.
// Throughput: one box per cycle without stalls; each stage moves when the next has room.
// Reset (synchronous, active low) empties the pipeline and clears every plane to zero.
`timescale 1ns / 1ps
`include "aabb_frustum_cull_macros.svh"

module aabb_frustum_cull (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]      paddr,
    input  logic [afc_pkg::DATA_W-1:0]       pwdata,
    output logic [afc_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_min_x,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_min_y,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_min_z,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_max_x,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_max_y,
    input  logic signed [afc_pkg::COORD_BITS-1:0] i_box_max_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_verdict
);
    import afc_pkg::*;

    t_plane   planes [PLANE_COUNT];
    t_coord   n_min [AXES];
    t_coord   n_max [AXES];
    t_coord   r_min [AXES];
    t_coord   r_max [AXES];
    t_prod    prod [PLANE_COUNT][CORNERS][AXES];
    logic     box_empty;
    t_verdict verdict;
    logic     r_v1;
    logic     r_v2;
    logic     r_v3;
    logic     rdy1;
    logic     rdy2;
    logic     rdy3;

    // Plane registers on the configuration port.
    afc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (planes)
    );

    // A stage takes a new beat when it is empty or its contents move on.
    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Input register.
    assign n_min[0] = i_box_min_x;
    assign n_min[1] = i_box_min_y;
    assign n_min[2] = i_box_min_z;
    assign n_max[0] = i_box_max_x;
    assign n_max[1] = i_box_max_y;
    assign n_max[2] = i_box_max_z;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // Corner products.
    afc_dot u_dot (
        .i_clk    (i_clk),
        .i_load   (rdy2),
        .i_min    (r_min),
        .i_max    (r_max),
        .i_planes (planes),
        .o_prod   (prod),
        .o_empty  (box_empty)
    );

    // Distances and verdict.
    afc_class u_class (
        .i_clk     (i_clk),
        .i_load    (rdy3),
        .i_prod    (prod),
        .i_empty   (box_empty),
        .i_planes  (planes),
        .o_verdict (verdict)
    );

    assign o_valid   = r_v3;
    assign o_verdict = verdict;

    // Back-pressure only appears when every stage holds a beat.
    `AFC_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && r_v3)
    // An empty result stage always takes the beat waiting in front of it.
    `AFC_ASSERT_NXT(a_no_bubble, i_clk, i_rst_n, r_v2 && !r_v3, r_v3)
    // A product stage blocked by a stalled result keeps its beat.
    `AFC_ASSERT_NXT(a_hold_mid, i_clk, i_rst_n, r_v2 && r_v3 && i_stall, r_v2 && r_v3)

endmodule
